// File: rtl/hexapod_cosine_gait_generator_top_macros.svh
// Assertion helpers used by the bound checker in rtl/hcg_checker.sv.
`ifndef HEXAPOD_COSINE_GAIT_GENERATOR_TOP_MACROS_SVH
`define HEXAPOD_COSINE_GAIT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication on the rising edge of clk.
`define HCG_ASSERT_IMP(lbl, rst_e, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_e) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the rising edge of clk.
`define HCG_ASSERT_NEXT(lbl, rst_e, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_e) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hcg_pkg.sv
`default_nettype none
package hcg_pkg;

  localparam int LEGS           = 6;
  localparam int LEG_W          = 3;
  localparam int JOINT_W        = 3;
  localparam int JOINTS_PER_LEG = 6;
  localparam int JOINT_SLOTS    = 8;
  localparam int KINDS          = 3;
  localparam int COS_TABLE_BITS = 10;
  localparam int QR_W           = COS_TABLE_BITS - 2;
  localparam int QN             = 2 ** QR_W;
  localparam int ANG_W          = 16;
  localparam int POS_W          = 16;
  localparam int TIME_W         = 32;
  localparam int REGS           = 5;
  localparam int PADDR_W        = 5;
  localparam int APB_W          = 32;
  localparam int Q14_W          = 15;
  localparam int COS_W          = 16;
  localparam int LIM_W          = 6;
  localparam int AMP_W          = 7;
  localparam int NUM_W          = 22;
  localparam int P_W            = 20;
  localparam int RECIP_W        = 22;
  localparam int PROD_W         = P_W + RECIP_W;
  localparam int DIV_SHIFT      = 24;
  localparam int MID_SHIFT      = 14;
  localparam int ROUND_SHIFT    = 4;
  localparam int OUT_DATA_W     = 24;
  localparam int OUT_PAD_W      = OUT_DATA_W - (LEG_W + JOINT_W + POS_W);

  localparam logic [63:0] TURN_PER_MS = 64'd1467945251641000646;
  localparam logic [31:0] TURN_LO     = TURN_PER_MS[31:0];
  localparam logic [31:0] TURN_HI     = TURN_PER_MS[63:32];
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // floor(n / 80) = floor(floor(n / 16) / 5); bias keeps the divide-by-5 operand positive
  localparam logic signed [NUM_W-1:0] ROUND_HALF = NUM_W'(40);
  localparam logic signed [NUM_W-1:0] DIV_BIAS   = NUM_W'(5 * 2 ** 16);
  localparam logic [RECIP_W-1:0]      RECIP5     = RECIP_W'((2 ** DIV_SHIFT + 4) / 5);

  localparam logic [ANG_W-1:0] QTURN = 16'h4000;
  localparam logic [ANG_W-1:0] HTURN = 16'h8000;

  typedef logic [ANG_W-1:0] offs_t [REGS];

  typedef enum logic [2:0] {
    REG_OFF_RF = 3'd0,
    REG_OFF_LM = 3'd1,
    REG_OFF_RM = 3'd2,
    REG_OFF_LR = 3'd3,
    REG_OFF_RR = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    logic [ANG_W-1:0]   base;
    logic [LEG_W-1:0]   leg;
    logic [JOINT_W-1:0] joint;
    logic               last;
  } item_t;

  typedef struct packed {
    logic                    valid;
    logic [LEG_W-1:0]        leg;
    logic [JOINT_W-1:0]      joint;
    logic signed [POS_W-1:0] position;
    logic                    last;
  } result_t;

  localparam logic signed [LIM_W-1:0] UPPER_TENTHS [KINDS][JOINT_SLOTS] = '{
    '{ 6'sd2,  6'sd12, 6'sd4, 6'sd22, -6'sd10, 6'sd2, 6'sd0, 6'sd0 },
    '{ 6'sd0,  6'sd2,  6'sd4, 6'sd16, -6'sd12, 6'sd5, 6'sd0, 6'sd0 },
    '{ 6'sd2, -6'sd10, 6'sd0, 6'sd26, -6'sd8,  6'sd4, 6'sd0, 6'sd0 }
  };

  localparam logic signed [LIM_W-1:0] LOWER_TENTHS [KINDS][JOINT_SLOTS] = '{
    '{ -6'sd2,  6'sd8,  6'sd0, 6'sd14, -6'sd22, 6'sd2, 6'sd0, 6'sd0 },
    '{  6'sd0, -6'sd4,  6'sd0, 6'sd12, -6'sd16, 6'sd5, 6'sd0, 6'sd0 },
    '{ -6'sd6, -6'sd8, -6'sd6, 6'sd6,  -6'sd22, 6'sd2, 6'sd0, 6'sd0 }
  };

  localparam logic [ANG_W-1:0] JOINT_PHASE [KINDS][JOINT_SLOTS] = '{
    '{ 16'h0, 16'h0, QTURN, HTURN, 16'h0, 16'h0, 16'h0, 16'h0 },
    '{ 16'h0, 16'h0, QTURN, 16'h0, HTURN, 16'h0, 16'h0, 16'h0 },
    '{ 16'h0, 16'h0, HTURN, 16'h0, HTURN, 16'h0, 16'h0, 16'h0 }
  };

  function automatic logic [63:0] sat_one(logic [63:0] p);
    return (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
  endfunction

  function automatic logic [Q14_W-1:0] to_q14(logic [63:0] v);
    return Q14_W'((v + 64'd32768) >> 16);
  endfunction

  // Quarter-turn cosine or sine in Q1.14, Horner Taylor series in Q30
  function automatic logic [Q14_W-1:0] quarter_entry(int r, logic want_sin);
    logic [63:0] u30;
    logic [63:0] x30;
    logic [63:0] x2;
    logic [63:0] c;
    logic [63:0] s;
    u30 = 64'(r) << (32 - COS_TABLE_BITS);
    x30 = (u30 * HALF_PI_Q30) >> 30;
    x2  = (x30 * x30) >> 30;
    c = ONE_Q30;
    c = sat_one(((x2 * c) >> 30) / 90);
    c = sat_one(((x2 * c) >> 30) / 56);
    c = sat_one(((x2 * c) >> 30) / 30);
    c = sat_one(((x2 * c) >> 30) / 12);
    c = sat_one(((x2 * c) >> 30) / 2);
    s = ONE_Q30;
    s = sat_one(((x2 * s) >> 30) / 110);
    s = sat_one(((x2 * s) >> 30) / 72);
    s = sat_one(((x2 * s) >> 30) / 42);
    s = sat_one(((x2 * s) >> 30) / 20);
    s = sat_one(((x2 * s) >> 30) / 6);
    s = (x30 * s) >> 30;
    return want_sin ? to_q14(s) : to_q14(c);
  endfunction

endpackage
`default_nettype wire

// File: rtl/hexapod_cosine_gait_generator_top.sv
`default_nettype none
// Cosine gait generator for a six-legged walker.
// Slave stream: one 32-bit time stamp in ms per control tick.
// Master stream: 36 joint setpoints per tick, joint by joint, legs lf, rf, lm, rm, lr, rr
//   within each joint; tlast marks the final setpoint of the tick.
// APB port: five 16-bit leg phase offsets (right front .. right rear) at 0x00..0x10,
//   in units of 2^-16 turn; write only while the block is idle.
// Path: input and product registers, sequencer, datapath stages A to E, output register.
// Throughput: one setpoint per cycle while m_tready is high; the sequencer walks the
//   36 leg/joint slots of a tick one by one. Up to two further time stamps queue
//   in the front stages while a tick is being expanded.
// Reset (rst, synchronous) clears all offsets to zero and empties every stage.
// While a setpoint waits with m_tready low, the sequencer and datapath hold in place;
//   nothing is dropped or repeated, and input accepts stop once the queue fills.
module hexapod_cosine_gait_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hcg_pkg::TIME_W-1:0]     s_tdata,   // [31:0] time_ms
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hcg_pkg::OUT_DATA_W-1:0] m_tdata,   // [2:0] leg_index, [5:3] joint_index,
                                                    // [21:6] position, [23:22] zero
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcg_pkg::PADDR_W-1:0]    paddr,
  input  logic [hcg_pkg::APB_W-1:0]      pwdata,
  output logic [hcg_pkg::APB_W-1:0]      prdata,
  output logic                           pready
);
  import hcg_pkg::*;

  offs_t   offs;
  item_t   item;
  result_t result;
  logic    adv;

  assign pready = 1'b1;
  assign adv    = !result.valid || m_tready;

  hcg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .offs    (offs)
  );

  hcg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .adv      (adv),
    .item     (item)
  );

  hcg_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (item),
    .offs   (offs),
    .result (result)
  );

  assign m_tvalid = result.valid;
  assign m_tlast  = result.last;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, result.position, result.joint, result.leg};

endmodule
`default_nettype wire

// File: rtl/hcg_regs.sv
`default_nettype none
module hcg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hcg_pkg::PADDR_W-1:0] paddr,
  input  logic [hcg_pkg::APB_W-1:0]   pwdata,
  output logic [hcg_pkg::APB_W-1:0]   prdata,
  output hcg_pkg::offs_t              offs
);
  import hcg_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGS; i++) begin
        offs[i] <= '0;
      end
    end else if (wr) begin
      case (idx)
        REG_OFF_RF: offs[REG_OFF_RF] <= pwdata[ANG_W-1:0];
        REG_OFF_LM: offs[REG_OFF_LM] <= pwdata[ANG_W-1:0];
        REG_OFF_RM: offs[REG_OFF_RM] <= pwdata[ANG_W-1:0];
        REG_OFF_LR: offs[REG_OFF_LR] <= pwdata[ANG_W-1:0];
        REG_OFF_RR: offs[REG_OFF_RR] <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_OFF_RF: prdata = APB_W'(offs[REG_OFF_RF]);
      REG_OFF_LM: prdata = APB_W'(offs[REG_OFF_LM]);
      REG_OFF_RM: prdata = APB_W'(offs[REG_OFF_RM]);
      REG_OFF_LR: prdata = APB_W'(offs[REG_OFF_LR]);
      REG_OFF_RR: prdata = APB_W'(offs[REG_OFF_RR]);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/hcg_seq.sv
`default_nettype none
module hcg_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [hcg_pkg::TIME_W-1:0] s_tdata,
  input  logic                       adv,
  output hcg_pkg::item_t             item
);
  import hcg_pkg::*;

  logic               t_valid;
  logic [TIME_W-1:0]  t_data;
  logic [63:0]        mul_lo;
  logic [63:0]        mul_hi;
  logic               p_valid;
  logic [31:0]        p_lo;
  logic [31:0]        p_hi;
  logic [31:0]        base_sum;
  logic               busy;
  logic [ANG_W-1:0]   base;
  logic [LEG_W-1:0]   leg;
  logic [JOINT_W-1:0] joint;
  logic               at_last;
  logic               emit;
  logic               load;
  logic               p_ready;

  assign mul_lo   = t_data * TURN_LO;
  assign mul_hi   = t_data * TURN_HI;
  assign base_sum = p_lo + p_hi;

  assign at_last  = (joint == JOINT_W'(JOINTS_PER_LEG - 1)) && (leg == LEG_W'(LEGS - 1));
  assign emit     = busy && adv;
  assign load     = p_valid && (!busy || (emit && at_last));
  assign p_ready  = !p_valid || load;
  assign s_tready = !t_valid || p_ready;

  assign item.valid = busy;
  assign item.base  = base;
  assign item.leg   = leg;
  assign item.joint = joint;
  assign item.last  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      p_valid <= 1'b0;
      busy    <= 1'b0;
      leg     <= '0;
      joint   <= '0;
    end else begin
      if (s_tready) begin
        t_valid <= s_tvalid;
      end
      if (p_ready) begin
        p_valid <= t_valid;
      end
      if (load) begin
        busy  <= 1'b1;
        leg   <= '0;
        joint <= '0;
      end else if (emit) begin
        if (at_last) begin
          busy <= 1'b0;
        end
        if (leg == LEG_W'(LEGS - 1)) begin
          leg   <= '0;
          joint <= joint + JOINT_W'(1);
        end else begin
          leg <= leg + LEG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      t_data <= s_tdata;
    end
    if (p_ready && t_valid) begin
      p_lo <= mul_lo[63:32];
      p_hi <= mul_hi[31:0];
    end
    if (load) begin
      base <= base_sum[31:16];
    end
  end

endmodule
`default_nettype wire

// File: rtl/hcg_datapath.sv
`default_nettype none
module hcg_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  hcg_pkg::item_t    item,
  input  hcg_pkg::offs_t    offs,
  output hcg_pkg::result_t  result
);
  import hcg_pkg::*;

  typedef struct packed {
    logic [LEG_W-1:0]   leg;
    logic [JOINT_W-1:0] joint;
    logic               last;
  } tag_t;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // stage A: angle
  logic               a_v;
  tag_t               a_tag;
  logic [ANG_W-1:0]   a_ang;
  logic [ANG_W-1:0]   off_sel;
  logic [1:0]         in_kind;

  // stage B: cosine and limits
  logic                    b_v;
  tag_t                    b_tag;
  logic signed [COS_W-1:0] b_cos;
  logic signed [AMP_W-1:0] b_dif;
  logic signed [AMP_W-1:0] b_sum;
  logic [COS_TABLE_BITS-1:0] idx;
  logic [1:0]              quad;
  logic [QR_W-1:0]         qr;
  logic [Q14_W-1:0]        cos_rom [QN];
  logic [Q14_W-1:0]        sin_rom [QN];
  logic signed [COS_W-1:0] cpos;
  logic signed [COS_W-1:0] spos;
  logic signed [COS_W-1:0] cos_sel;
  logic [1:0]              a_kind;
  logic signed [LIM_W-1:0] up;
  logic signed [LIM_W-1:0] lo;

  // stage C: numerator
  logic                    c_v;
  tag_t                    c_tag;
  logic signed [NUM_W-1:0] c_num;
  logic signed [NUM_W-1:0] dif_x;
  logic signed [NUM_W-1:0] cos_x;
  logic signed [NUM_W-1:0] sum_x;

  // stage D: biased quotient operand
  logic                    d_v;
  tag_t                    d_tag;
  logic [P_W-1:0]          d_p;
  logic signed [NUM_W-1:0] rnd;
  logic signed [NUM_W-1:0] biased;

  // stage E: reciprocal product
  logic                    e_v;
  tag_t                    e_tag;
  logic [PROD_W-1:0]       e_prod;

  for (genvar g = 0; g < QN; g++) begin : g_qrom
    localparam logic [Q14_W-1:0] COS_ENTRY = quarter_entry(g, 1'b0);
    localparam logic [Q14_W-1:0] SIN_ENTRY = quarter_entry(g, 1'b1);
    assign cos_rom[g] = COS_ENTRY;
    assign sin_rom[g] = SIN_ENTRY;
  end

  assign in_kind = item.leg[2:1];
  assign a_kind  = a_tag.leg[2:1];

  always_comb begin
    case (item.leg)
      LEG_W'(1): off_sel = offs[REG_OFF_RF];
      LEG_W'(2): off_sel = offs[REG_OFF_LM];
      LEG_W'(3): off_sel = offs[REG_OFF_RM];
      LEG_W'(4): off_sel = offs[REG_OFF_LR];
      LEG_W'(5): off_sel = offs[REG_OFF_RR];
      default:   off_sel = '0;
    endcase
  end

  assign idx  = a_ang[ANG_W-1 -: COS_TABLE_BITS];
  assign quad = idx[COS_TABLE_BITS-1 -: 2];
  assign qr   = idx[QR_W-1:0];
  assign cpos = signed'({1'b0, cos_rom[qr]});
  assign spos = signed'({1'b0, sin_rom[qr]});
  assign up   = UPPER_TENTHS[a_kind][a_tag.joint];
  assign lo   = LOWER_TENTHS[a_kind][a_tag.joint];

  always_comb begin
    case (quad)
      QUAD_I:   cos_sel = cpos;
      QUAD_II:  cos_sel = -spos;
      QUAD_III: cos_sel = -cpos;
      QUAD_IV:  cos_sel = spos;
      default:  cos_sel = cpos;
    endcase
  end

  assign dif_x = NUM_W'(b_dif);
  assign cos_x = NUM_W'(b_cos);
  assign sum_x = NUM_W'(b_sum);

  assign rnd    = (c_num + ROUND_HALF) >>> ROUND_SHIFT;
  assign biased = rnd + DIV_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v        <= 1'b0;
      b_v        <= 1'b0;
      c_v        <= 1'b0;
      d_v        <= 1'b0;
      e_v        <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      a_v          <= item.valid;
      b_v          <= a_v;
      c_v          <= b_v;
      d_v          <= c_v;
      e_v          <= d_v;
      result.valid <= e_v;

      result.leg      <= e_tag.leg;
      result.joint    <= e_tag.joint;
      result.last     <= e_tag.last;
      result.position <= signed'(e_prod[DIV_SHIFT + POS_W - 1:DIV_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag <= '{leg: item.leg, joint: item.joint, last: item.last};
      a_ang <= item.base + JOINT_PHASE[in_kind][item.joint] + off_sel;

      b_tag <= a_tag;
      b_cos <= cos_sel;
      b_dif <= AMP_W'(up) - AMP_W'(lo);
      b_sum <= AMP_W'(up) + AMP_W'(lo);

      c_tag <= b_tag;
      c_num <= (dif_x * cos_x) + (sum_x <<< MID_SHIFT);

      d_tag <= c_tag;
      d_p   <= P_W'(biased);

      e_tag  <= d_tag;
      e_prod <= PROD_W'(d_p) * PROD_W'(RECIP5);
    end
  end

endmodule
`default_nettype wire

// File: rtl/hcg_checker.sv
`default_nettype none
`include "hexapod_cosine_gait_generator_top_macros.svh"
module hcg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hcg_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import hcg_pkg::*;

  logic [LEG_W-1:0]   leg;
  logic [JOINT_W-1:0] joint;
  logic               pad_zero;

  assign leg      = m_tdata[LEG_W-1:0];
  assign joint    = m_tdata[LEG_W + JOINT_W - 1:LEG_W];
  assign pad_zero = (m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] == '0);

  `HCG_ASSERT_NEXT(a_hold, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled transaction changed")
  `HCG_ASSERT_IMP(a_fields, rst, m_tvalid, (leg < LEG_W'(LEGS)) && (joint < JOINT_W'(JOINTS_PER_LEG)) && pad_zero, "leg or joint out of range")
  `HCG_ASSERT_IMP(a_last, rst, m_tvalid, m_tlast == ((leg == LEG_W'(LEGS - 1)) && (joint == JOINT_W'(JOINTS_PER_LEG - 1))), "tlast misplaced")
  `HCG_ASSERT_NEXT(a_order, rst, m_tvalid && m_tready && !m_tlast, !m_tvalid || (leg == LEG_W'(0)) || (leg == $past(leg) + LEG_W'(1)), "setpoint order broken")
  `HCG_ASSERT_NEXT(a_reset, 1'b0, rst, !m_tvalid, "output valid after reset")

endmodule

bind hexapod_cosine_gait_generator_top hcg_checker u_hcg_checker (.*);
`default_nettype wire

// File: tb/hexapod_cosine_gait_generator_checker.sv
`timescale 1ns / 1ps
module hexapod_cosine_gait_generator_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [hcg_pkg::TIME_W-1:0]     s_tdata,   // [31:0] time_ms
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [hcg_pkg::OUT_DATA_W-1:0] m_tdata,   // [2:0] leg_index, [5:3] joint_index,
                                                    // [21:6] position, [23:22] zero
  input  logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcg_pkg::PADDR_W-1:0]    paddr,
  input  logic [hcg_pkg::APB_W-1:0]      pwdata,
  input  logic [hcg_pkg::APB_W-1:0]      prdata,
  input  logic                           pready,
  output int                             failures,
  output int                             pending,
  output int                             setpoints_seen
);

  localparam int          ANGLE_BITS       = 16;
  localparam int          LUT_BITS         = hcg_pkg::COS_TABLE_BITS;
  localparam int          LUT_SIZE         = 2 ** LUT_BITS;
  localparam int          LEG_COUNT        = hcg_pkg::LEGS;
  localparam int          JOINT_COUNT      = hcg_pkg::JOINTS_PER_LEG;
  localparam int          TICK_SETPOINTS   = LEG_COUNT * JOINT_COUNT;
  localparam logic [63:0] MS_TO_TURN       = 64'd1467945251641000646;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;
  localparam logic [15:0] QUARTER          = 16'h4000;
  localparam logic [15:0] HALF             = 16'h8000;

  typedef struct packed {
    logic [hcg_pkg::LEG_W-1:0]        leg;
    logic [hcg_pkg::JOINT_W-1:0]      joint;
    logic signed [hcg_pkg::POS_W-1:0] position;
    logic                             last;
  } setpoint_t;

  int upper_tenths [3][8] = '{
    '{ 2,  12, 4, 22, -10, 2, 0, 0 },
    '{ 0,   2, 4, 16, -12, 5, 0, 0 },
    '{ 2, -10, 0, 26,  -8, 4, 0, 0 }
  };
  int lower_tenths [3][8] = '{
    '{ -2,  8,  0, 14, -22, 2, 0, 0 },
    '{  0, -4,  0, 12, -16, 5, 0, 0 },
    '{ -6, -8, -6,  6, -22, 2, 0, 0 }
  };
  logic [15:0] joint_phase_turn [3][8] = '{
    '{ 16'h0, 16'h0, QUARTER, HALF,  16'h0, 16'h0, 16'h0, 16'h0 },
    '{ 16'h0, 16'h0, QUARTER, 16'h0, HALF,  16'h0, 16'h0, 16'h0 },
    '{ 16'h0, 16'h0, HALF,    16'h0, HALF,  16'h0, 16'h0, 16'h0 }
  };

  logic signed [15:0] cosine_lut [LUT_SIZE];
  logic [15:0]        leg_offset [hcg_pkg::REGS];
  setpoint_t          expected_setpoints [$];

  function automatic logic [63:0] horner_step(input logic [63:0] acc, input logic [63:0] x2,
                                              input logic [63:0] k);
    logic [63:0] p;
    p = ((x2 * acc) >> 30) / k;
    return (p >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - p;
  endfunction

  function automatic int cosine_q14(input int idx);
    logic [1:0]  quadrant;
    logic [63:0] x30;
    logic [63:0] x2;
    logic [63:0] c;
    logic [63:0] s;
    int          cv;
    int          sv;
    quadrant = 2'(idx >> (LUT_BITS - 2));
    x30 = ((64'(idx % (LUT_SIZE / 4)) << (32 - LUT_BITS)) * QUARTER_TURN_Q30) >> 30;
    x2  = (x30 * x30) >> 30;
    c = horner_step(UNIT_Q30, x2, 64'd90);
    c = horner_step(c, x2, 64'd56);
    c = horner_step(c, x2, 64'd30);
    c = horner_step(c, x2, 64'd12);
    c = horner_step(c, x2, 64'd2);
    s = horner_step(UNIT_Q30, x2, 64'd110);
    s = horner_step(s, x2, 64'd72);
    s = horner_step(s, x2, 64'd42);
    s = horner_step(s, x2, 64'd20);
    s = horner_step(s, x2, 64'd6);
    s = (x30 * s) >> 30;
    cv = int'((c + 64'd32768) >> 16);
    sv = int'((s + 64'd32768) >> 16);
    case (quadrant)
      2'd0:    return cv;
      2'd1:    return -sv;
      2'd2:    return -cv;
      default: return sv;
    endcase
  endfunction

  initial begin
    for (int i = 0; i < LUT_SIZE; i++) cosine_lut[i] = 16'(cosine_q14(i));
  end

  task automatic predict_tick(input logic [hcg_pkg::TIME_W-1:0] time_ms);
    logic [63:0] turns;
    logic [15:0] angle;
    logic [15:0] offset;
    int          kind;
    int          cv;
    int          num;
    int          rounded;
    int          count;
    setpoint_t   sp;
    turns = 64'(time_ms) * MS_TO_TURN;
    count = 0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
        kind = leg / 2;
        if (leg == 0) offset = 16'h0;
        else offset = leg_offset[leg - 1];
        angle = turns[63:48] + joint_phase_turn[kind][j % 8] + offset;
        cv = cosine_lut[angle >> (ANGLE_BITS - LUT_BITS)];
        num = (upper_tenths[kind][j % 8] - lower_tenths[kind][j % 8]) * cv
            + (upper_tenths[kind][j % 8] + lower_tenths[kind][j % 8]) * 16384 + 40;
        rounded = (num >= 0) ? num / 80 : -((-num + 79) / 80);
        sp.leg      = hcg_pkg::LEG_W'(leg);
        sp.joint    = hcg_pkg::JOINT_W'(j);
        sp.position = hcg_pkg::POS_W'(rounded);
        sp.last     = (count == TICK_SETPOINTS - 1);
        expected_setpoints.push_back(sp);
        count++;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    int        reg_index;
    setpoint_t got;
    setpoint_t want;
    if (rst) begin
      expected_setpoints.delete();
      foreach (leg_offset[i]) leg_offset[i] = 16'h0;
    end else begin
      if (psel && penable && pready) begin
        reg_index = int'(paddr >> 2);
        if (reg_index < hcg_pkg::REGS) begin
          if (pwrite) begin
            leg_offset[reg_index] = pwdata[15:0];
          end else if (prdata !== hcg_pkg::APB_W'(leg_offset[reg_index])) begin
            $error("offset register %0d: expected %h, got %h", reg_index,
                   hcg_pkg::APB_W'(leg_offset[reg_index]), prdata);
            failures++;
          end
        end
      end
      if (m_tvalid && m_tready) begin
        got.leg      = m_tdata[hcg_pkg::LEG_W-1:0];
        got.joint    = m_tdata[hcg_pkg::LEG_W +: hcg_pkg::JOINT_W];
        got.position = m_tdata[hcg_pkg::LEG_W + hcg_pkg::JOINT_W +: hcg_pkg::POS_W];
        got.last     = m_tlast;
        setpoints_seen++;
        if (expected_setpoints.size() == 0) begin
          $error("setpoint with no tick pending: leg %0d joint %0d", got.leg, got.joint);
          failures++;
        end else begin
          want = expected_setpoints.pop_front();
          if (got.leg !== want.leg) begin
            $error("leg_index: expected %0d, got %0d", want.leg, got.leg);
            failures++;
          end
          if (got.joint !== want.joint) begin
            $error("joint_index: expected %0d, got %0d", want.joint, got.joint);
            failures++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            failures++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_tick(s_tdata);
    end
    pending <= expected_setpoints.size();
  end

endmodule

// File: tb/hexapod_cosine_gait_generator_top_test.sv
`timescale 1ns / 1ps
module hexapod_cosine_gait_generator_top_test;
  import hcg_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RESET_CYCLES   = 6;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 32;
  localparam int TICK_PERIOD_MS = 64;
  localparam int ADDR_SLOTS     = 2 ** (PADDR_W - 2);

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [TIME_W-1:0]     s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [APB_W-1:0]      pwdata   = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire                   m_tlast;
  wire [APB_W-1:0]       prdata;
  wire                   pready;

  int          failures;
  int          pending;
  int          setpoints_seen;
  int          cycle_count    = 0;
  int          ticks_sent     = 0;
  int          settings_used  = 0;
  int          gap_pct        = 0;
  int          stall_pct      = 0;
  bit          hold_armed     = 1'b0;
  logic [31:0] tick_clock     = '0;
  logic [31:0] corner_times [13] = '{
    32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd6, 32'd13, 32'd64, 32'd1000
  };

  always #4 clk = ~clk;

  hexapod_cosine_gait_generator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hexapod_cosine_gait_generator_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .failures       (failures),
    .pending        (pending),
    .setpoints_seen (setpoints_seen)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold off the setpoint stream in random bursts or one long stretch on request.
  initial begin : setpoint_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [PADDR_W-1:0] reg_addr(input int index);
    return PADDR_W'(index * 4);
  endfunction

  task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [APB_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_offsets();
    for (int idx = 0; idx < REGS; idx++) apb_access(1'b0, reg_addr(idx), '0);
  endtask

  task automatic write_offsets(input logic [15:0] rf, input logic [15:0] lm,
                               input logic [15:0] rm, input logic [15:0] lr,
                               input logic [15:0] rr, input logic [15:0] junk);
    apb_access(1'b1, reg_addr(REG_OFF_RF), {junk, rf});
    apb_access(1'b1, reg_addr(REG_OFF_LM), {junk, lm});
    apb_access(1'b1, reg_addr(REG_OFF_RM), {junk, rm});
    apb_access(1'b1, reg_addr(REG_OFF_LR), {junk, lr});
    apb_access(1'b1, reg_addr(REG_OFF_RR), {junk, rr});
    for (int idx = REGS; idx < ADDR_SLOTS; idx++) apb_access(1'b1, reg_addr(idx), $urandom);
    read_offsets();
    settings_used++;
  endtask

  task automatic send_time(input logic [TIME_W-1:0] time_ms);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= time_ms;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0, 1:    send_time($urandom);
        2:       send_time($urandom_range(0, 4095));
        default: begin
          tick_clock += TICK_PERIOD_MS;
          send_time(tick_clock);
        end
      endcase
    end
  endtask

  // Drop valid and wait until every predicted setpoint has been taken.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_offsets();
    settings_used++;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (corner_times[i]) send_time(corner_times[i]);
    wait_idle();

    write_offsets(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5C3);
    for (int i = 0; i < 6; i++) send_time(corner_times[i]);
    wait_idle();

    write_offsets(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
    gap_pct   = 30;
    stall_pct = 30;
    send_random(40);

    // Fill the pipeline against a long sink hold-off.
    gap_pct    = 0;
    hold_armed = 1'b1;
    send_random(12);
    wait_idle();

    write_offsets(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    gap_pct   = 50;
    stall_pct = 50;
    send_random(40);
    wait_idle();

    write_offsets(16'h0001, 16'hFFFE, 16'h4000, 16'hC000, 16'($urandom), 16'h0000);
    gap_pct   = 10;
    stall_pct = 10;
    send_random(40);

    gap_pct   = 0;
    stall_pct = 0;
    send_random(30);
    wait_idle();

    $display("Covered %0d time stamps and %0d setpoints across %0d offset settings,",
             ticks_sent, setpoints_seen, settings_used);
    $display("including zero and all-ones offsets, a long sink hold-off and a full drain.");
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: hexapod_cosine_gait_generator_top.f
+incdir+rtl
rtl/hcg_pkg.sv
rtl/hcg_regs.sv
rtl/hcg_seq.sv
rtl/hcg_datapath.sv
rtl/hexapod_cosine_gait_generator_top.sv
rtl/hcg_checker.sv
tb/hexapod_cosine_gait_generator_checker.sv
tb/hexapod_cosine_gait_generator_top_test.sv
